// ===== hdl/gmctu_pkg.sv =====
// Package for the gated multi-countdown tick unit.
// Item codes, mode codes, flag and countdown indexes, lane control type.
// No dependencies.
package gmctu_pkg;

	localparam int NUM_CNT      = 11;
	localparam int CNT_SEL_W    = $clog2(NUM_CNT);
	localparam int FLAG_W       = 10;
	localparam int CNT_OUT_W    = 16;
	localparam int TICK_W       = 32;
	localparam int LOAD_W       = 16;

	localparam int DEF_COUNTER_WIDTH = 16;
	localparam int DEF_SLOW_DIVIDER  = 50;

	// request kinds carried on s_tuser
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	localparam logic [2:0] MODE_FOREGROUND = 3'd0;
	localparam logic [2:0] MODE_TRANSMIT   = 3'd1;
	localparam logic [2:0] MODE_MONITOR    = 3'd2;
	localparam logic [2:0] MODE_RECEIVE    = 3'd3;
	localparam logic [2:0] MODE_POWER_SAVE = 3'd4;

	localparam logic [1:0] TONE_OFF      = 2'd0;
	localparam logic [1:0] TONE_SCANNING = 2'd1;

	// event flag bits
	localparam int FLG_SLICE    = 0;
	localparam int FLG_40MS     = 1;
	localparam int FLG_500MS    = 2;
	localparam int FLG_TX_TMO   = 3;
	localparam int FLG_PS_DUE   = 4;
	localparam int FLG_PS_END   = 5;
	localparam int FLG_DW_DUE   = 6;
	localparam int FLG_SCAN_DUE = 7;
	localparam int FLG_TAIL     = 8;
	localparam int FLG_FM_DUE   = 9;

	// countdown indexes
	localparam int CD_TX_TIMER = 0;
	localparam int CD_DELAY    = 1;
	localparam int CD_DTONE    = 2;
	localparam int CD_ATONE    = 3;
	localparam int CD_PS_WAIT  = 4;
	localparam int CD_PS_PER   = 5;
	localparam int CD_DUAL     = 6;
	localparam int CD_SCAN     = 7;
	localparam int CD_TAIL     = 8;
	localparam int CD_FM       = 9;
	localparam int CD_VOX      = 10;

	// config register indexes (paddr[2])
	localparam logic REG_DW_ENABLE  = 1'b0;
	localparam logic REG_FM_FEATURE = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
	} cdn_ctl_t;

endpackage

// ===== hdl/gmctu_cdn.sv =====
// One countdown lane: load, gated decrement, zero detect.
// Depends on gmctu_pkg (cdn_ctl_t).
module gmctu_cdn
	import gmctu_pkg::*;
#(
	parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cdn_ctl_t                 ctl,
	input  logic [COUNTER_WIDTH-1:0] load_value,
	output logic [COUNTER_WIDTH-1:0] count_next,
	output logic                     hit
);

	logic [COUNTER_WIDTH-1:0] count_q;
	logic                     nonzero;

	assign nonzero = (count_q != '0);

	always_comb begin
		count_next = count_q;
		if (ctl.load) begin
			count_next = load_value;
		end else if (ctl.step && nonzero) begin
			count_next = count_q - COUNTER_WIDTH'(1);
		end
	end

	// reaches zero on this step
	assign hit = ctl.step && (count_q == COUNTER_WIDTH'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

endmodule

// ===== hdl/gated_multi_countdown_tick_unit_top.sv =====
// Top level of the gated multi-countdown tick unit.
// Depends on gmctu_pkg and gmctu_cdn.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tuser: kind; s_tdata: select, value, mode, scan state
// m_*      out  m_tvalid/m_tready   m_tdata: flags, counter value, tick count
// apb      in   psel/penable/pready paddr[2] selects dual watch or FM feature register
//
// One request per cycle unless s_tready is low; all state updates in the cycle it is accepted.
// The result is registered; it waits in the skid register while the sink stalls a full result register.
// A two-entry output (result register plus skid register) keeps s_tready
// registered; it drops only when both hold results the sink has not taken.
// Reset clears tick count, phase, countdowns and flags; no clearing pass.
module gated_multi_countdown_tick_unit_top
	import gmctu_pkg::*;
#(
	parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH,
	parameter int SLOW_DIVIDER  = DEF_SLOW_DIVIDER
) (
	input  logic        clk,
	input  logic        arst_n,
	// [3:0] counter_select, [19:4] load_value, [22:20] function_mode,
	// [23] scan_active, [25:24] tone_scan_mode, [26] fm_scan_active, [31:27] zero
	input  logic [31:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [9:0] flags, [25:10] counter_value, [57:26] tick_value, [63:58] zero
	output logic [63:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PHASE_W = (SLOW_DIVIDER > 1) ? $clog2(SLOW_DIVIDER) : 1;
	localparam int EXT_W   = (COUNTER_WIDTH > LOAD_W) ? COUNTER_WIDTH : LOAD_W;

	// config registers
	logic dw_en_q;
	logic fm_en_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_en_q <= 1'b0;
			fm_en_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_DW_ENABLE:  dw_en_q <= pwdata[0];
				REG_FM_FEATURE: fm_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DW_ENABLE:  prdata = {31'd0, dw_en_q};
			REG_FM_FEATURE: prdata = {31'd0, fm_en_q};
			default:        prdata = '0;
		endcase
	end

	// request fields
	op_t                  op;
	logic [CNT_SEL_W-1:0] sel;
	logic [LOAD_W-1:0]    load_value;
	logic [2:0]           mode;
	logic                 scan_on;
	logic [1:0]           tone;
	logic                 fm_scan_on;
	logic                 acc;

	assign op         = op_t'(s_tuser);
	assign sel        = s_tdata[3:0];
	assign load_value = s_tdata[19:4];
	assign mode       = s_tdata[22:20];
	assign scan_on    = s_tdata[23];
	assign tone       = s_tdata[25:24];
	assign fm_scan_on = s_tdata[26];
	assign acc        = s_tvalid && s_tready;

	logic is_tick;
	logic is_load;
	logic is_clear;

	always_comb begin
		is_tick  = 1'b0;
		is_load  = 1'b0;
		is_clear = 1'b0;
		case (op)
			OP_TICK:  is_tick  = acc;
			OP_LOAD:  is_load  = acc;
			OP_CLEAR: is_clear = acc;
			default: ;
		endcase
	end

	// state
	logic [TICK_W-1:0]  tick_q;
	logic [PHASE_W-1:0] phase_q;
	logic [FLAG_W-1:0]  flags_q;

	logic slow_tick;
	logic forty_tick;
	assign slow_tick  = (phase_q == PHASE_W'(SLOW_DIVIDER - 1));
	assign forty_tick = (tick_q[1:0] == 2'b11);

	// countdown gates on a tick
	logic               busy_tx;
	logic               busy_rx;
	logic [NUM_CNT-1:0] gate;

	assign busy_tx = (mode == MODE_TRANSMIT) || (mode == MODE_MONITOR);
	assign busy_rx = busy_tx || (mode == MODE_RECEIVE);

	always_comb begin
		gate              = '1;
		gate[CD_TX_TIMER] = slow_tick;
		gate[CD_PS_WAIT]  = (mode == MODE_FOREGROUND);
		gate[CD_PS_PER]   = (mode == MODE_POWER_SAVE);
		gate[CD_DUAL]     = !scan_on && (tone == TONE_OFF) && dw_en_q && !busy_rx;
		gate[CD_SCAN]     = (scan_on || (tone == TONE_SCANNING)) && !busy_tx;
		gate[CD_FM]       = fm_en_q && fm_scan_on && !busy_rx;
	end

	logic [EXT_W-1:0]         lv_ext;
	logic [COUNTER_WIDTH-1:0] lv_cnt;
	assign lv_ext = EXT_W'(load_value);
	assign lv_cnt = lv_ext[COUNTER_WIDTH-1:0];

	logic [COUNTER_WIDTH-1:0] cnt_next [NUM_CNT];
	logic [NUM_CNT-1:0]       cnt_hit;

	for (genvar i = 0; i < NUM_CNT; i++) begin : g_cdn
		cdn_ctl_t ctl;
		assign ctl.load = is_load && (sel == CNT_SEL_W'(i));
		assign ctl.step = is_tick && gate[i];

		gmctu_cdn #(
			.COUNTER_WIDTH(COUNTER_WIDTH)
		) u_cdn (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.load_value(lv_cnt),
			.count_next(cnt_next[i]),
			.hit       (cnt_hit[i])
		);
	end

	// next flags
	logic [FLAG_W-1:0] flags_set;
	logic [FLAG_W-1:0] flags_next;

	always_comb begin
		flags_set               = '0;
		flags_set[FLG_SLICE]    = 1'b1;
		flags_set[FLG_40MS]     = forty_tick;
		flags_set[FLG_500MS]    = slow_tick;
		flags_set[FLG_TX_TMO]   = cnt_hit[CD_TX_TIMER];
		flags_set[FLG_PS_DUE]   = cnt_hit[CD_PS_WAIT];
		flags_set[FLG_PS_END]   = cnt_hit[CD_PS_PER];
		flags_set[FLG_DW_DUE]   = cnt_hit[CD_DUAL];
		flags_set[FLG_SCAN_DUE] = cnt_hit[CD_SCAN];
		flags_set[FLG_TAIL]     = cnt_hit[CD_TAIL];
		flags_set[FLG_FM_DUE]   = cnt_hit[CD_FM];

		flags_next = flags_q;
		if (is_tick) begin
			flags_next = flags_q | flags_set;
		end else if (is_clear) begin
			flags_next = flags_q & ~load_value[FLAG_W-1:0];
		end
	end

	logic [TICK_W-1:0]  tick_next;
	logic [PHASE_W-1:0] phase_next;

	assign tick_next  = is_tick ? tick_q + TICK_W'(1) : tick_q;
	assign phase_next = !is_tick ? phase_q :
	                    slow_tick ? '0 : phase_q + PHASE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			phase_q <= '0;
			flags_q <= '0;
		end else begin
			tick_q  <= tick_next;
			phase_q <= phase_next;
			flags_q <= flags_next;
		end
	end

	// readback of the selected countdown after this request
	logic [EXT_W-1:0]     cv_ext;
	logic [CNT_OUT_W-1:0] cv;

	always_comb begin
		cv_ext = '0;
		if (sel < CNT_SEL_W'(NUM_CNT)) begin
			cv_ext = EXT_W'(cnt_next[sel]);
		end
		cv = cv_ext[CNT_OUT_W-1:0];
	end

	logic [63:0] res;
	assign res = {6'd0, tick_next, cv, flags_next};

	// result register plus skid register
	logic [63:0] out_q;
	logic        out_vld_q;
	logic [63:0] skid_q;
	logic        skid_vld_q;
	logic        out_free;

	assign out_free = m_tready || !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (out_free) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end
			end else if (acc) begin
				if (out_free) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign s_tready = !skid_vld_q;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// checks
	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick |=> tick_q == $past(tick_q) + TICK_W'(1))
		else $error("tick count did not advance on a tick request");

	a_slice_flag: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick |=> flags_q[FLG_SLICE] && m_tvalid)
		else $error("timeslice flag or result missing after a tick request");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(tick_q) && $stable(flags_q) && $stable(phase_q))
		else $error("state changed without an accepted request");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_W'(SLOW_DIVIDER - 1))
		else $error("slow phase out of range");

endmodule
